// ===== src/arpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the ARP cache engine.
package arpc_pkg;

   // table geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int SLOT_W  = 4;
   localparam int EXT_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   // field widths
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int STAMP_W = 32;
   localparam int KIND_W  = 2;
   localparam int OP_W    = 16;
   localparam int LEARN_W = 2;

   // request kinds
   localparam logic [KIND_W-1:0] REQ_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] REQ_PACKET = 2'd1;
   localparam logic [KIND_W-1:0] REQ_ADD    = 2'd2;
   localparam logic [KIND_W-1:0] REQ_TICK   = 2'd3;

   // learn outcomes
   localparam logic [LEARN_W-1:0] LEARN_NONE      = 2'd0;
   localparam logic [LEARN_W-1:0] LEARN_REFRESHED = 2'd1;
   localparam logic [LEARN_W-1:0] LEARN_STORED    = 2'd2;
   localparam logic [LEARN_W-1:0] LEARN_FULL      = 2'd3;

   // ARP operation that asks for a reply
   localparam logic [OP_W-1:0] OP_REQUEST = 16'd1;

   typedef struct packed {
      logic [KIND_W-1:0] req_type;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
      logic [IP_W-1:0]   target_addr;
      logic [OP_W-1:0]   opcode;
   } req_item_type;

   typedef struct packed {
      logic               hit;
      logic [MAC_W-1:0]   mac_out;
      logic [LEARN_W-1:0] learn_result;
      logic [SLOT_W-1:0]  slot;
      logic               send_reply;
      logic [IP_W-1:0]    reply_ip;
      logic [MAC_W-1:0]   reply_mac;
   } rsp_item_type;

   // one table entry as held in memory (valid bits live in flops)
   typedef struct packed {
      logic [IP_W-1:0]    ip;
      logic [MAC_W-1:0]   mac;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // low slot bits of an entry index
   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(idx);
      return ext[SLOT_W-1:0];
   endfunction

endpackage

// ===== src/arpc_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the ARP cache engine.
interface arpc_req_if;
   logic                              valid;
   logic                              ready;
   logic [arpc_pkg::KIND_W-1:0]       req_type;
   logic [arpc_pkg::IP_W-1:0]         ip;
   logic [arpc_pkg::MAC_W-1:0]        mac;
   logic [arpc_pkg::IP_W-1:0]         target_addr;
   logic [arpc_pkg::OP_W-1:0]         opcode;

   modport source (output valid, req_type, ip, mac, target_addr, opcode, input ready);
   modport sink   (input valid, req_type, ip, mac, target_addr, opcode, output ready);
endinterface

interface arpc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              hit;
   logic [arpc_pkg::MAC_W-1:0]        mac_out;
   logic [arpc_pkg::LEARN_W-1:0]      learn_result;
   logic [arpc_pkg::SLOT_W-1:0]       slot;
   logic                              send_reply;
   logic [arpc_pkg::IP_W-1:0]         reply_ip;
   logic [arpc_pkg::MAC_W-1:0]        reply_mac;

   modport source (output valid, hit, mac_out, learn_result, slot, send_reply,
                   reply_ip, reply_mac, input ready);
   modport sink   (input valid, hit, mac_out, learn_result, slot, send_reply,
                   reply_ip, reply_mac, output ready);
endinterface

// ===== src/arpc_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
module arpc_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/arpc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: scans the entry memory, picks match and placement, writes back.
module arpc_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   // item in
   input  logic                            req_fire,
   input  arpc_pkg::req_item_type          req_item,
   output logic                            req_idle,
   // configuration
   input  logic [arpc_pkg::IP_W-1:0]       own_ip,
   // result out
   input  logic                            out_free,
   output logic                            done,
   output arpc_pkg::rsp_item_type          result,
   // entry memory
   output logic                            ram_wr_en,
   output logic [arpc_pkg::IDX_W-1:0]      ram_wr_addr,
   output logic [arpc_pkg::ENTRY_W-1:0]    ram_wr_data,
   output logic                            ram_rd_en,
   output logic [arpc_pkg::IDX_W-1:0]      ram_rd_addr,
   input  logic [arpc_pkg::ENTRY_W-1:0]    ram_rd_data
);
   import arpc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);

   // control state
   state_type            state_ff, state_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [STAMP_W-1:0]   now_ff, now_in;
   logic                 rd_vld_ff, rd_vld_in;

   // per-item working registers
   req_item_type         item_ff, item_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 match_found_ff, match_found_in;
   logic [IDX_W-1:0]     match_idx_ff, match_idx_in;
   logic [MAC_W-1:0]     match_mac_ff, match_mac_in;
   logic                 inv_found_ff, inv_found_in;
   logic [IDX_W-1:0]     inv_idx_ff, inv_idx_in;
   logic                 old_found_ff, old_found_in;
   logic [IDX_W-1:0]     old_idx_ff, old_idx_in;
   logic [STAMP_W-1:0]   old_stamp_ff, old_stamp_in;

   entry_type            rd_entry;
   logic                 rd_entry_valid;
   logic                 pick_found;
   logic [IDX_W-1:0]     pick_idx;
   logic                 wr_req;
   logic [IDX_W-1:0]     wr_idx;
   logic                 leave_decide;

   assign rd_entry       = entry_type'(ram_rd_data);
   assign rd_entry_valid = valid_ff[rd_idx_ff];
   assign req_idle       = (state_ff == ST_IDLE);
   assign done           = (state_ff == ST_DECIDE);
   assign leave_decide   = done && out_free;

   // placement: first free slot, else oldest slot stamped before now
   assign pick_found = inv_found_ff || old_found_ff;
   assign pick_idx   = inv_found_ff ? inv_idx_ff : old_idx_ff;

   // result and write-back of the finished scan
   always_comb begin
      result = '0;
      wr_req = 1'b0;
      wr_idx = pick_idx;
      unique case (item_ff.req_type)
         REQ_LOOKUP: begin
            if (match_found_ff) begin
               result.hit     = 1'b1;
               result.mac_out = match_mac_ff;
               result.slot    = slot_of(match_idx_ff);
            end
         end
         REQ_PACKET: begin
            if (match_found_ff) begin
               wr_req              = 1'b1;
               wr_idx              = match_idx_ff;
               result.learn_result = LEARN_REFRESHED;
               result.slot         = slot_of(match_idx_ff);
            end else if (pick_found) begin
               wr_req              = 1'b1;
               result.learn_result = LEARN_STORED;
               result.slot         = slot_of(pick_idx);
            end else begin
               result.learn_result = LEARN_FULL;
            end
            if (item_ff.target_addr == own_ip && item_ff.opcode == OP_REQUEST) begin
               result.send_reply = 1'b1;
               result.reply_ip   = item_ff.ip;
               result.reply_mac  = item_ff.mac;
            end
         end
         REQ_ADD: begin
            if (pick_found) begin
               wr_req              = 1'b1;
               result.learn_result = LEARN_STORED;
               result.slot         = slot_of(pick_idx);
            end else begin
               result.learn_result = LEARN_FULL;
            end
         end
         REQ_TICK: begin
         end
         default: begin
         end
      endcase
   end

   // memory ports
   assign ram_wr_en   = leave_decide && wr_req;
   assign ram_wr_addr = wr_idx;
   assign ram_wr_data = ENTRY_W'({item_ff.ip, item_ff.mac, now_ff});
   assign ram_rd_en   = (state_ff == ST_SCAN) && (issue_ff < CNT_END);
   assign ram_rd_addr = issue_ff[IDX_W-1:0];

   // next-state logic
   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      now_in         = now_ff;
      rd_vld_in      = 1'b0;
      item_in        = item_ff;
      issue_in       = issue_ff;
      rd_idx_in      = rd_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_mac_in   = match_mac_ff;
      inv_found_in   = inv_found_ff;
      inv_idx_in     = inv_idx_ff;
      old_found_in   = old_found_ff;
      old_idx_in     = old_idx_ff;
      old_stamp_in   = old_stamp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_in        = req_item;
               issue_in       = '0;
               match_found_in = 1'b0;
               inv_found_in   = 1'b0;
               old_found_in   = 1'b0;
               old_stamp_in   = now_ff;
               if (req_item.req_type == REQ_TICK) begin
                  now_in   = now_ff + STAMP_W'(1);
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue one read a cycle
            if (ram_rd_en) begin
               issue_in  = issue_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[IDX_W-1:0];
            end
            // evaluate the entry read last cycle
            if (rd_vld_ff) begin
               if (rd_entry_valid && rd_entry.ip == item_ff.ip && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = rd_idx_ff;
                  match_mac_in   = rd_entry.mac;
               end
               if (!rd_entry_valid && !inv_found_ff) begin
                  inv_found_in = 1'b1;
                  inv_idx_in   = rd_idx_ff;
               end
               if (rd_entry_valid && rd_entry.stamp < old_stamp_ff) begin
                  old_found_in = 1'b1;
                  old_idx_in   = rd_idx_ff;
                  old_stamp_in = rd_entry.stamp;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (leave_decide) begin
               if (wr_req) begin
                  valid_in[wr_idx] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         now_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         now_ff    <= now_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      issue_ff       <= issue_in;
      rd_idx_ff      <= rd_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_mac_ff   <= match_mac_in;
      inv_found_ff   <= inv_found_in;
      inv_idx_ff     <= inv_idx_in;
      old_found_ff   <= old_found_in;
      old_idx_ff     <= old_idx_in;
      old_stamp_ff   <= old_stamp_in;
   end

endmodule

// ===== src/arp_cache_engine.sv =====
`timescale 1ns / 1ps
// Top level of the ARP cache engine: config register, sequencer, memory, output register.
//
//  channel   | direction | handshake           | contents
//  ----------+-----------+---------------------+----------------------------------------
//  req_chan  | in        | valid / ready       | req_type, ip, mac, target_addr, opcode
//  rsp_chan  | out       | valid / ready       | hit, mac_out, learn_result, slot, reply
//  csr       | in        | csr_we              | own_ip (csr_wdata)
//
//  Lookup, packet and add items make one memory read per entry on the single read port,
//  evaluate each entry as its registered read data returns, then pass through the
//  decide/write-back state before the next accept. A tick goes straight to decide.
//  Reset clears all valid bits, the tick counter and own_ip at once; no clearing pass.
//  A result waits in the output register; the engine holds its write-back until that
//  register is free, and accepts one item at a time.
module arp_cache_engine (
   input  logic                       clock,
   input  logic                       reset,
   arpc_req_if.sink                   req_chan,
   arpc_rsp_if.source                 rsp_chan,
   input  logic                       csr_we,
   input  logic [arpc_pkg::IP_W-1:0]  csr_wdata
);
   import arpc_pkg::*;

   logic [IP_W-1:0]     own_ip_ff, own_ip_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_data_ff, rsp_data_in;

   req_item_type        req_item;
   logic                req_idle;
   logic                req_fire;
   logic                out_free;
   logic                done;
   rsp_item_type        result;

   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;

   // input side
   assign req_item.req_type    = req_chan.req_type;
   assign req_item.ip          = req_chan.ip;
   assign req_item.mac         = req_chan.mac;
   assign req_item.target_addr = req_chan.target_addr;
   assign req_item.opcode      = req_chan.opcode;
   assign req_chan.ready       = req_idle;
   assign req_fire             = req_chan.valid && req_idle;

   // configuration register
   assign own_ip_in = csr_we ? csr_wdata : own_ip_ff;

   // output register
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = (done && out_free) ? 1'b1 :
                         (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = (done && out_free) ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         own_ip_ff    <= own_ip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hit          = rsp_data_ff.hit;
   assign rsp_chan.mac_out      = rsp_data_ff.mac_out;
   assign rsp_chan.learn_result = rsp_data_ff.learn_result;
   assign rsp_chan.slot         = rsp_data_ff.slot;
   assign rsp_chan.send_reply   = rsp_data_ff.send_reply;
   assign rsp_chan.reply_ip     = rsp_data_ff.reply_ip;
   assign rsp_chan.reply_mac    = rsp_data_ff.reply_mac;

   // sequencer
   arpc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_item    (req_item),
      .req_idle    (req_idle),
      .own_ip      (own_ip_ff),
      .out_free    (out_free),
      .done        (done),
      .result      (result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // entry memory: ip, mac and stamp of every slot
   arpc_ram #(
      .DEPTH  (ENTRIES),
      .WIDTH  (ENTRY_W),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== src/arpc_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions of the ARP cache engine and their binding.
module arpc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          hit,
   input  logic [arpc_pkg::MAC_W-1:0]    mac_out,
   input  logic [arpc_pkg::LEARN_W-1:0]  learn_result,
   input  logic [arpc_pkg::SLOT_W-1:0]   slot,
   input  logic                          send_reply,
   input  logic [arpc_pkg::IP_W-1:0]     reply_ip,
   input  logic [arpc_pkg::MAC_W-1:0]    reply_mac
);
   import arpc_pkg::*;

   // one item at a time: taking an item closes the input
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input still open after an item was taken");

   // a hit only comes from a lookup, which learns nothing and sends no reply
   a_hit_is_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && hit |-> learn_result == LEARN_NONE && !send_reply)
      else $error("hit item carries learn or reply fields");

   // reply address fields are zero unless a reply is flagged
   a_reply_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !send_reply |-> reply_ip == '0 && reply_mac == '0)
      else $error("reply fields set without send_reply");

   // a full table names no slot
   a_full_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && learn_result == LEARN_FULL |-> slot == '0 && !hit)
      else $error("table-full item carries a slot");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(mac_out) && $stable(slot)
                                  && $stable(learn_result))
      else $error("result item changed while stalled");

endmodule

bind arp_cache_engine arpc_checker u_arpc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .hit          (rsp_chan.hit),
   .mac_out      (rsp_chan.mac_out),
   .learn_result (rsp_chan.learn_result),
   .slot         (rsp_chan.slot),
   .send_reply   (rsp_chan.send_reply),
   .reply_ip     (rsp_chan.reply_ip),
   .reply_mac    (rsp_chan.reply_mac)
);

// ===== dv/arpc_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the ARP cache engine: tracks the table, predicts each result and compares.
module arpc_scoreboard (
   input  logic                      clock,
   input  logic                      reset,
   arpc_req_if                       req_mon,
   arpc_rsp_if                       rsp_mon,
   input  logic                      csr_we,
   input  logic [arpc_pkg::IP_W-1:0] csr_wdata,
   output int                        fail_count,
   output int                        pending,
   output int                        checked_count,
   output int                        hit_count,
   output int                        full_count,
   output int                        reply_count
);
   import arpc_pkg::*;

   localparam int SHOW_LIMIT = 10;

   // shadow copy of the cache table, tick counter and own address
   logic               tbl_valid [ENTRIES];
   logic [IP_W-1:0]    tbl_ip    [ENTRIES];
   logic [MAC_W-1:0]   tbl_mac   [ENTRIES];
   logic [STAMP_W-1:0] tbl_stamp [ENTRIES];
   logic [STAMP_W-1:0] tick_now;
   logic [IP_W-1:0]    local_ip;

   rsp_item_type expected_rsp_q [$];
   int           shown;

   initial begin
      fail_count    = 0;
      pending       = 0;
      checked_count = 0;
      hit_count     = 0;
      full_count    = 0;
      reply_count   = 0;
      shown         = 0;
   end

   // lowest-index valid entry holding addr, or -1
   function automatic int find_entry(input logic [IP_W-1:0] addr);
      for (int i = 0; i < ENTRIES; i++) begin
         if (tbl_valid[i] && tbl_ip[i] == addr) return i;
      end
      return -1;
   endfunction

   // first free entry, else the oldest stamp strictly below now; -1 when full
   function automatic int claim_entry(input logic [IP_W-1:0] addr,
                                      input logic [MAC_W-1:0] hw);
      int                 pick;
      logic [STAMP_W-1:0] oldest;
      pick   = -1;
      oldest = tick_now;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!tbl_valid[i]) begin
            pick = i;
            break;
         end
         if (tbl_stamp[i] < oldest) begin
            oldest = tbl_stamp[i];
            pick   = i;
         end
      end
      if (pick >= 0) begin
         tbl_valid[pick] = 1'b1;
         tbl_ip[pick]    = addr;
         tbl_mac[pick]   = hw;
         tbl_stamp[pick] = tick_now;
      end
      return pick;
   endfunction

   // apply one request to the shadow table and return the result it should give
   function automatic rsp_item_type resolve_request(input req_item_type rq);
      rsp_item_type r;
      int           s;
      r = '0;
      case (rq.req_type)
         REQ_LOOKUP: begin
            s = find_entry(rq.ip);
            if (s >= 0) begin
               r.hit     = 1'b1;
               r.mac_out = tbl_mac[s];
               r.slot    = SLOT_W'(s);
            end
         end
         REQ_PACKET, REQ_ADD: begin
            // a direct add never looks for a match
            s = (rq.req_type == REQ_PACKET) ? find_entry(rq.ip) : -1;
            if (s >= 0) begin
               tbl_mac[s]     = rq.mac;
               tbl_stamp[s]   = tick_now;
               r.learn_result = LEARN_REFRESHED;
               r.slot         = SLOT_W'(s);
            end else begin
               s = claim_entry(rq.ip, rq.mac);
               if (s >= 0) begin
                  r.learn_result = LEARN_STORED;
                  r.slot         = SLOT_W'(s);
               end else begin
                  r.learn_result = LEARN_FULL;
               end
            end
            // reply is flagged even when nothing could be stored
            if (rq.req_type == REQ_PACKET && rq.target_addr == local_ip &&
                rq.opcode == OP_REQUEST) begin
               r.send_reply = 1'b1;
               r.reply_ip   = rq.ip;
               r.reply_mac  = rq.mac;
            end
         end
         default: begin
            tick_now = tick_now + STAMP_W'(1);
         end
      endcase
      return r;
   endfunction

   task automatic flag_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         if (shown < SHOW_LIMIT) begin
            shown++;
            $display("mismatch in result %0d, %s: expected 0x%0h, got 0x%0h",
                     checked_count, name, want, got);
         end
      end
   endtask

   // sample both channels and the register port at each rising edge
   always @(posedge clock) begin : monitor
      rsp_item_type got;
      rsp_item_type want;
      req_item_type rq;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_ip[i]    = '0;
            tbl_mac[i]   = '0;
            tbl_stamp[i] = '0;
         end
         tick_now = '0;
         local_ip = '0;
         expected_rsp_q.delete();
      end else begin
         if (csr_we) local_ip = csr_wdata;

         // compare the result item first; its request was accepted earlier
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.hit          = rsp_mon.hit;
            got.mac_out      = rsp_mon.mac_out;
            got.learn_result = rsp_mon.learn_result;
            got.slot         = rsp_mon.slot;
            got.send_reply   = rsp_mon.send_reply;
            got.reply_ip     = rsp_mon.reply_ip;
            got.reply_mac    = rsp_mon.reply_mac;
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               if (shown < SHOW_LIMIT) begin
                  shown++;
                  $display("unexpected result item with nothing outstanding");
               end
            end else begin
               want = expected_rsp_q.pop_front();
               if (want.hit) hit_count++;
               if (want.learn_result == LEARN_FULL) full_count++;
               if (want.send_reply) reply_count++;
               flag_field("hit", 64'(want.hit), 64'(got.hit));
               flag_field("mac_out", 64'(want.mac_out), 64'(got.mac_out));
               flag_field("learn_result", 64'(want.learn_result),
                          64'(got.learn_result));
               flag_field("slot", 64'(want.slot), 64'(got.slot));
               flag_field("send_reply", 64'(want.send_reply), 64'(got.send_reply));
               flag_field("reply_ip", 64'(want.reply_ip), 64'(got.reply_ip));
               flag_field("reply_mac", 64'(want.reply_mac), 64'(got.reply_mac));
               checked_count++;
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            rq.req_type    = req_mon.req_type;
            rq.ip          = req_mon.ip;
            rq.mac         = req_mon.mac;
            rq.target_addr = req_mon.target_addr;
            rq.opcode      = req_mon.opcode;
            expected_rsp_q.push_back(resolve_request(rq));
         end
      end
      pending = expected_rsp_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the ARP cache engine: clock, reset, stimulus, stalls and verdict.
module tb_top;
   import arpc_pkg::*;

   localparam int ITEMS_PER_PHASE = 200;
   localparam int PHASES          = 7;
   localparam int LONG_HOLD       = 400;
   localparam int IDLE_LIMIT      = 3000;
   localparam int POOL_MAX        = 48;
   localparam int TAIL_CYCLES     = 40;

   // ARP reply operation, used as a non-request opcode
   localparam logic [OP_W-1:0] OP_REPLY = 16'd2;

   logic            clock = 1'b0;
   logic            reset;
   logic            csr_we;
   logic [IP_W-1:0] csr_wdata;

   int fail_count, pending, checked_count, hit_count, full_count, reply_count;
   int hold_seq    = 0;
   int idle_cycles = 0;
   int sent_count  = 0;
   int cfg_writes  = 0;
   int burst_left  = 0;
   bit no_idle     = 1'b0;

   // addresses reused across items so that lookups and refreshes hit
   logic [IP_W-1:0] ip_pool [POOL_MAX];
   int              pool_size;
   logic [IP_W-1:0] own_ip_copy;

   arpc_req_if req_chan();
   arpc_rsp_if rsp_chan();

   arp_cache_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   arpc_scoreboard scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .hit_count     (hit_count),
      .full_count    (full_count),
      .reply_count   (reply_count)
   );

   always #6 clock = ~clock;

   function automatic req_item_type make_req(input logic [KIND_W-1:0] kind,
                                             input logic [IP_W-1:0]   addr,
                                             input logic [MAC_W-1:0]  hw,
                                             input logic [IP_W-1:0]   tgt,
                                             input logic [OP_W-1:0]   op);
      req_item_type it;
      it.req_type    = kind;
      it.ip          = addr;
      it.mac         = hw;
      it.target_addr = tgt;
      it.opcode      = op;
      return it;
   endfunction

   // offer one item, in bursts with random gaps, and wait for its accept
   task automatic send_req(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = no_idle ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= it.req_type;
      req_chan.ip          <= it.ip;
      req_chan.mac         <= it.mac;
      req_chan.target_addr <= it.target_addr;
      req_chan.opcode      <= it.opcode;
      do begin
         @(posedge clock);
      end while (req_chan.ready !== 1'b1);
      sent_count++;
   endtask

   // stop offering until every outstanding result has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending != 0);
   endtask

   // own_ip is only written with the engine idle
   task automatic write_own_ip(input logic [IP_W-1:0] value);
      wait_drained();
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we      <= 1'b0;
      own_ip_copy = value;
      cfg_writes++;
   endtask

   // result-side stalls: changing patterns plus a long hold on request
   initial begin : rsp_stall_gen
      int mode;
      int mode_left;
      int hold_left;
      int seen_seq;
      int beat;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      seen_seq  = 0;
      beat      = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != seen_seq) begin
            seen_seq  = hold_seq;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         beat++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_chan.ready <= ((beat % 7) < 2);
               default: rsp_chan.ready <= ((beat % 5) != 0);
            endcase
         end
      end
   end

   // watchdog: too long without any accepted item ends the run
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: %0d cycles without an accepted item", idle_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      logic [KIND_W-1:0] kind;
      logic [IP_W-1:0]   addr;
      logic [IP_W-1:0]   tgt;
      logic [IP_W-1:0]   own_value;
      logic [MAC_W-1:0]  hw;
      logic [OP_W-1:0]   op;
      int                roll;
      int                tick_pct;

      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_wdata            <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.req_type    <= '0;
      req_chan.ip          <= '0;
      req_chan.mac         <= '0;
      req_chan.target_addr <= '0;
      req_chan.opcode      <= '0;
      own_ip_copy          = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, refresh, duplicates, full table, eviction
      send_req(make_req(REQ_LOOKUP, '0, '0, '0, '0));
      send_req(make_req(REQ_ADD, '1, '1, '0, '0));
      send_req(make_req(REQ_ADD, '0, '0, '1, '1));
      send_req(make_req(REQ_LOOKUP, '1, '0, '0, '0));
      send_req(make_req(REQ_LOOKUP, '0, '1, '1, '1));
      send_req(make_req(REQ_PACKET, '1, 48'h0123_4567_89ab, '0, OP_REQUEST));
      send_req(make_req(REQ_PACKET, 32'h0a00_0001, 48'h0a0b_0c0d_0e0f, 32'h0a00_00fe,
                        OP_REQUEST));
      send_req(make_req(REQ_PACKET, 32'h0a00_0002, 48'h1122_3344_5566, '0, '1));
      // second entry with the same address; lookups still see the first
      send_req(make_req(REQ_ADD, '1, 48'hffff_0000_ffff, '0, '0));
      send_req(make_req(REQ_LOOKUP, '1, '0, '0, '0));
      // fill every slot at the same stamp, then overflow
      for (int k = 0; k < 13; k++) begin
         send_req(make_req(REQ_ADD, IP_W'(32'hc0a8_0100 + k), MAC_W'({$urandom, $urandom}),
                           '0, '0));
      end
      send_req(make_req(REQ_PACKET, 32'hc0a8_02aa, 48'h5555_aaaa_5555, '0, OP_REQUEST));
      send_req(make_req(REQ_PACKET, 32'h0a00_0001, 48'haaaa_5555_aaaa, '0, OP_REQUEST));
      // one tick makes every stamp older than now; slot 0 goes first
      send_req(make_req(REQ_TICK, $urandom, MAC_W'({$urandom, $urandom}), $urandom,
                        OP_W'($urandom)));
      send_req(make_req(REQ_ADD, 32'hc0a8_02aa, 48'h5555_aaaa_5555, '0, '0));
      send_req(make_req(REQ_LOOKUP, '1, '0, '0, '0));
      write_own_ip('1);
      send_req(make_req(REQ_PACKET, '0, '1, '1, OP_REQUEST));

      // random phases, each with its own own_ip, address pool and tick rate
      for (int ph = 0; ph < PHASES; ph++) begin
         pool_size = (ph % 3 == 0) ? 8 : ((ph % 3 == 1) ? 20 : POOL_MAX);
         for (int k = 0; k < pool_size; k++) ip_pool[k] = $urandom;
         if (ph == 1) begin
            ip_pool[0] = '0;
            ip_pool[1] = '1;
         end
         case (ph % 4)
            0:       own_value = $urandom;
            1:       own_value = '1;
            2:       own_value = '0;
            default: own_value = ip_pool[0];
         endcase
         write_own_ip(own_value);
         tick_pct = (ph % 3 == 0) ? 3 : ((ph % 3 == 1) ? 12 : 25);
         no_idle  = (ph == 5);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long result stall while items keep coming
            if (ph == 2 && n == 40) hold_seq <= hold_seq + 1;
            if (ph == 4 && n == 100) wait_drained();

            roll = $urandom_range(0, 99);
            if (roll < 30) kind = REQ_LOOKUP;
            else if (roll < 60) kind = REQ_PACKET;
            else if (roll < 100 - tick_pct) kind = REQ_ADD;
            else kind = REQ_TICK;

            addr = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, pool_size - 1)]
                                                : $urandom;
            hw   = MAC_W'({$urandom, $urandom});
            roll = $urandom_range(0, 3);
            if (roll < 2) tgt = own_ip_copy;
            else if (roll == 2) tgt = ip_pool[$urandom_range(0, pool_size - 1)];
            else tgt = $urandom;
            roll = $urandom_range(0, 9);
            if (roll < 6) op = OP_REQUEST;
            else if (roll < 8) op = OP_REPLY;
            else op = OP_W'($urandom);

            send_req(make_req(kind, addr, hw, tgt, op));
         end
      end

      // drain, then allow for one item's latency before the verdict
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d requests over %0d own_ip settings, with bursty input, a long",
               sent_count, cfg_writes + 1);
      $display("result stall and drain pauses; %0d results: %0d hits, %0d full, %0d replies.",
               checked_count, hit_count, full_count, reply_count);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
